// ===== hw/rtl/vcdlex_pkg.sv =====
// vcdlex_pkg: shared types, character codes and helpers for the value change
// dump byte lexer. No dependencies; used by vcdlex_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package vcdlex_pkg;

   localparam int TIME_BITS_DEFAULT = 64;
   localparam int MAX_RESULTS       = 6;

   // character codes
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_1      = 8'h31;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_Z      = 8'h7a;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_E      = 8'h65;
   localparam logic [7:0] CHAR_N      = 8'h6e;
   localparam logic [7:0] CHAR_D      = 8'h64;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_KW_HOLD,
      MODE_KW,
      MODE_BODY_WS,
      MODE_BODY_WORD,
      MODE_BODY_HOLD,
      MODE_TIME,
      MODE_SC_VAL,
      MODE_SC_ID,
      MODE_VEC_VAL,
      MODE_VEC_GAP,
      MODE_VEC_ID
   } mode_type;

   typedef enum logic [2:0] {
      KIND_KEYWORD,
      KIND_BODY,
      KIND_SECTION_END,
      KIND_TIMESTAMP,
      KIND_VALUE,
      KIND_ID,
      KIND_CHANGE_END,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_MISSING_END,
      ERR_UNEXPECTED,
      ERR_EMPTY_TIME,
      ERR_OVERFLOW
   } err_code_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [63:0] time_value;
      logic [2:0]  error_code;
      logic        end_of_run;
   } rsp_word_type;

   // one queued result; timestamp and error code travel once per burst
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
   } slot_type;

   typedef struct packed {
      logic [2:0]                     count;
      slot_type [MAX_RESULTS-1:0]     slots;
      logic [63:0]                    time_value;
      err_code_type                   error_code;
   } burst_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

   // characters of the closing word, by position
   function automatic logic [7:0] end_char(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = CHAR_DOLLAR;
         2'd1:    r = CHAR_E;
         2'd2:    r = CHAR_N;
         default: r = CHAR_D;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vcdlex_core.sv =====
// vcdlex_core: lexer state and the single-pass decode of one byte into a burst
// of up to six result entries. Depends on vcdlex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcdlex_core
   import vcdlex_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_word_type in_word,
   output burst_type         burst
);

   localparam int PROD_BITS = TIME_BITS + 4;

   mode_type               mode_ff, mode_in;
   logic [TIME_BITS-1:0]   acc_ff, acc_in;
   logic                   dseen_ff, dseen_in;
   logic                   ddone_ff, ddone_in;
   logic [2:0]             hcnt_ff, hcnt_in;
   logic                   errl_ff, errl_in;

   logic [7:0]             c;
   logic                   ws;
   logic                   held_ext;
   logic [PROD_BITS-1:0]   prod;
   logic [TIME_BITS-1:0]   acc_keep;

   // burst pieces: flushed prefix, one byte, one closing entry
   logic                   flush_on;
   kind_type               flush_kind;
   logic                   flush_from;
   logic [2:0]             flush_to;
   logic                   byte_on;
   kind_type               byte_kind;
   logic                   tail_on;
   kind_type               tail_kind;
   err_code_type           tail_err;
   logic [63:0]            tail_time;
   logic [2:0]             fc;

   assign c        = in_word.byte_in;
   assign ws       = is_ws(c);
   // held bytes are always a prefix of the closing word, so the count says it all
   assign held_ext = (hcnt_ff < 3'd4) && (c == end_char(hcnt_ff[1:0]));
   assign prod     = (PROD_BITS'(acc_ff) << 3) + (PROD_BITS'(acc_ff) << 1)
                     + PROD_BITS'(c[3:0]);

   always_comb begin
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      dseen_in   = dseen_ff;
      ddone_in   = ddone_ff;
      hcnt_in    = hcnt_ff;
      errl_in    = errl_ff;
      flush_on   = 1'b0;
      flush_kind = KIND_KEYWORD;
      flush_from = 1'b0;
      flush_to   = hcnt_ff;
      byte_on    = 1'b0;
      byte_kind  = KIND_KEYWORD;
      tail_on    = 1'b0;
      tail_kind  = KIND_ERROR;
      tail_err   = ERR_NONE;

      if (!errl_ff) begin
         case (mode_ff)
            MODE_KW_HOLD: begin
               if (ws) begin
                  if (hcnt_ff == 3'd4) begin
                     hcnt_in   = 3'd0;
                     tail_on   = 1'b1;
                     tail_kind = KIND_SECTION_END;
                     mode_in   = MODE_IDLE;
                  end else begin
                     flush_on   = 1'b1;
                     flush_from = 1'b1;
                     hcnt_in    = 3'd0;
                     mode_in    = MODE_BODY_WS;
                  end
               end else if (held_ext) begin
                  hcnt_in = hcnt_ff + 3'd1;
               end else begin
                  flush_on   = 1'b1;
                  flush_from = 1'b1;
                  hcnt_in    = 3'd0;
                  byte_on    = 1'b1;
                  mode_in    = MODE_KW;
               end
            end
            MODE_KW: begin
               if (ws) begin
                  mode_in = MODE_BODY_WS;
               end else begin
                  byte_on = 1'b1;
               end
            end
            MODE_BODY_WS: begin
               if (c == CHAR_DOLLAR) begin
                  hcnt_in = 3'd1;
                  mode_in = MODE_BODY_HOLD;
               end else begin
                  byte_on   = 1'b1;
                  byte_kind = KIND_BODY;
                  if (!ws) begin
                     mode_in = MODE_BODY_WORD;
                  end
               end
            end
            MODE_BODY_WORD: begin
               byte_on   = 1'b1;
               byte_kind = KIND_BODY;
               if (ws) begin
                  mode_in = MODE_BODY_WS;
               end
            end
            MODE_BODY_HOLD: begin
               if (ws && (hcnt_ff == 3'd4)) begin
                  hcnt_in   = 3'd0;
                  tail_on   = 1'b1;
                  tail_kind = KIND_SECTION_END;
                  mode_in   = MODE_IDLE;
               end else if (!ws && held_ext) begin
                  hcnt_in = hcnt_ff + 3'd1;
               end else begin
                  flush_on   = 1'b1;
                  flush_kind = KIND_BODY;
                  hcnt_in    = 3'd0;
                  byte_on    = 1'b1;
                  byte_kind  = KIND_BODY;
                  mode_in    = ws ? MODE_BODY_WS : MODE_BODY_WORD;
               end
            end
            MODE_TIME: begin
               if (ws) begin
                  tail_on = 1'b1;
                  if (dseen_ff) begin
                     tail_kind = KIND_TIMESTAMP;
                     mode_in   = MODE_IDLE;
                  end else begin
                     tail_err = ERR_EMPTY_TIME;
                     errl_in  = 1'b1;
                  end
               end else if (ddone_ff) begin
                  ddone_in = 1'b1;
               end else if ((c >= CHAR_0) && (c <= CHAR_9)) begin
                  if (prod[PROD_BITS-1:TIME_BITS] != 4'd0) begin
                     tail_on  = 1'b1;
                     tail_err = ERR_OVERFLOW;
                     errl_in  = 1'b1;
                  end else begin
                     acc_in   = prod[TIME_BITS-1:0];
                     dseen_in = 1'b1;
                  end
               end else if (dseen_ff) begin
                  ddone_in = 1'b1;
               end else begin
                  tail_on  = 1'b1;
                  tail_err = ERR_EMPTY_TIME;
                  errl_in  = 1'b1;
               end
            end
            MODE_SC_VAL: begin
               if (ws) begin
                  tail_on  = 1'b1;
                  tail_err = ERR_UNEXPECTED;
                  errl_in  = 1'b1;
               end else begin
                  byte_on   = 1'b1;
                  byte_kind = KIND_ID;
                  mode_in   = MODE_SC_ID;
               end
            end
            MODE_SC_ID, MODE_VEC_ID: begin
               if (ws) begin
                  tail_on   = 1'b1;
                  tail_kind = KIND_CHANGE_END;
                  mode_in   = MODE_IDLE;
               end else begin
                  byte_on   = 1'b1;
                  byte_kind = KIND_ID;
               end
            end
            MODE_VEC_VAL: begin
               if (ws) begin
                  mode_in = MODE_VEC_GAP;
               end else begin
                  byte_on   = 1'b1;
                  byte_kind = KIND_VALUE;
               end
            end
            MODE_VEC_GAP: begin
               if (!ws) begin
                  byte_on   = 1'b1;
                  byte_kind = KIND_ID;
                  mode_in   = MODE_VEC_ID;
               end
            end
            default: begin
               // token start
               mode_in = MODE_IDLE;
               if (ws) begin
                  mode_in = MODE_IDLE;
               end else if (c == CHAR_DOLLAR) begin
                  hcnt_in = 3'd1;
                  mode_in = MODE_KW_HOLD;
               end else if (c == CHAR_HASH) begin
                  acc_in   = '0;
                  dseen_in = 1'b0;
                  ddone_in = 1'b0;
                  mode_in  = MODE_TIME;
               end else if ((c == CHAR_0) || (c == CHAR_1) || (c == CHAR_X)
                            || (c == CHAR_Z)) begin
                  byte_on   = 1'b1;
                  byte_kind = KIND_VALUE;
                  mode_in   = MODE_SC_VAL;
               end else if ((c == CHAR_B) || (c == CHAR_R)) begin
                  byte_on   = 1'b1;
                  byte_kind = KIND_VALUE;
                  mode_in   = MODE_VEC_VAL;
               end else begin
                  tail_on  = 1'b1;
                  tail_err = ERR_UNEXPECTED;
                  errl_in  = 1'b1;
               end
            end
         endcase

         // last byte closes whatever is open
         if (!errl_in && in_word.last_byte) begin
            case (mode_in)
               MODE_KW_HOLD, MODE_BODY_HOLD: begin
                  tail_on = 1'b1;
                  if (hcnt_in == 3'd4) begin
                     tail_kind = KIND_SECTION_END;
                  end else begin
                     flush_on   = 1'b1;
                     flush_to   = hcnt_in;
                     flush_kind = (mode_in == MODE_KW_HOLD) ? KIND_KEYWORD : KIND_BODY;
                     flush_from = (mode_in == MODE_KW_HOLD);
                     tail_err   = ERR_MISSING_END;
                  end
               end
               MODE_KW, MODE_BODY_WS, MODE_BODY_WORD: begin
                  tail_on  = 1'b1;
                  tail_err = ERR_MISSING_END;
               end
               MODE_TIME: begin
                  tail_on = 1'b1;
                  if (dseen_in) begin
                     tail_kind = KIND_TIMESTAMP;
                  end else begin
                     tail_err = ERR_EMPTY_TIME;
                  end
               end
               MODE_SC_ID, MODE_VEC_ID: begin
                  tail_on   = 1'b1;
                  tail_kind = KIND_CHANGE_END;
               end
               MODE_SC_VAL, MODE_VEC_VAL, MODE_VEC_GAP: begin
                  tail_on  = 1'b1;
                  tail_err = ERR_UNEXPECTED;
               end
               default: begin
                  // idle: a closing entry from this byte stands as it is
               end
            endcase
         end
      end

      // timestamp value as decoded, ahead of the end-of-run clear
      acc_keep = acc_in;

      if (in_word.last_byte) begin
         mode_in  = MODE_IDLE;
         acc_in   = '0;
         dseen_in = 1'b0;
         ddone_in = 1'b0;
         hcnt_in  = 3'd0;
         errl_in  = 1'b0;
      end
   end

   assign tail_time = (tail_kind == KIND_TIMESTAMP) ? 64'(acc_keep) : 64'd0;
   assign fc        = (flush_on && (flush_to > {2'b00, flush_from}))
                      ? (flush_to - {2'b00, flush_from}) : 3'd0;

   // lay the pieces out in emission order
   always_comb begin
      burst.count      = fc + {2'b00, byte_on} + {2'b00, tail_on};
      burst.time_value = tail_time;
      burst.error_code = (tail_on && (tail_kind == KIND_ERROR)) ? tail_err : ERR_NONE;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (3'(i) < fc) begin
            burst.slots[i].kind      = flush_kind;
            burst.slots[i].data_byte = end_char(2'(i + int'(flush_from)));
         end else if (byte_on && (3'(i) == fc)) begin
            burst.slots[i].kind      = byte_kind;
            burst.slots[i].data_byte = c;
         end else begin
            burst.slots[i].kind      = tail_kind;
            burst.slots[i].data_byte = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         acc_ff   <= '0;
         dseen_ff <= 1'b0;
         ddone_ff <= 1'b0;
         hcnt_ff  <= 3'd0;
         errl_ff  <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         dseen_ff <= dseen_in;
         ddone_ff <= ddone_in;
         hcnt_ff  <= hcnt_in;
         errl_ff  <= errl_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vcd_byte_stream_lexer_unit.sv =====
// vcd_byte_stream_lexer_unit: top level of the value change dump byte lexer.
// Depends on vcdlex_pkg and vcdlex_core.
`timescale 1ns / 1ps
`default_nettype none

// Tokenizes value change dump text one byte per word. A byte enters an input
// register, is decoded in one pass against the lexer state into a burst of
// zero to six result words, and the burst lands in a result queue that the
// rsp_ port drains one word per cycle while rsp_stall is low. A byte that
// yields at most one word leaves the queue free for the next, so plain text
// streams at one byte per clock unless rsp_ stalls; a byte that yields more
// words holds the queue and stalls the next byte, since the single result
// port is the bottleneck (flushes of a held dollar word and the last byte of
// a run, which also closes the open word, are what produce more than one).
// end_of_run marks the final word of each burst; a byte that yields nothing
// produces no word. After an error the block stays quiet until the word
// flagged last_byte, which also returns it to its reset state. Reset is
// synchronous, active high.
module vcd_byte_stream_lexer_unit
   import vcdlex_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   // input register
   logic                          in_valid_ff, in_valid_in;
   req_word_type                  in_word_ff, in_word_in;

   // result queue, slot zero is the head
   logic [2:0]                    out_count_ff, out_count_in;
   slot_type [MAX_RESULTS-1:0]    slots_ff, slots_in;
   logic [63:0]                   time_ff, time_in;
   err_code_type                  err_ff, err_in;

   logic                          req_take;
   logic                          rsp_take;
   logic                          queue_free;
   logic                          advance;
   burst_type                     new_burst;

   // queue can take a new burst when empty or draining its final word
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign queue_free = (out_count_ff == 3'd0) || ((out_count_ff == 3'd1) && rsp_take);
   assign advance    = in_valid_ff && queue_free;
   assign req_stall  = in_valid_ff && !queue_free;
   assign req_take   = req_valid && !req_stall;

   vcdlex_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_word (in_word_ff),
      .burst   (new_burst)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_count_in = out_count_ff;
      slots_in     = slots_ff;
      time_in      = time_ff;
      err_in       = err_ff;
      if (advance) begin
         out_count_in = new_burst.count;
         slots_in     = new_burst.slots;
         time_in      = new_burst.time_value;
         err_in       = new_burst.error_code;
      end else if (rsp_take) begin
         // pop the head
         out_count_in = out_count_ff - 3'd1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slots_in[i] = slots_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_count_ff <= 3'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      slots_ff   <= slots_in;
      time_ff    <= time_in;
      err_ff     <= err_in;
   end

   // head of the queue drives the port
   always_comb begin
      rsp_valid           = out_count_ff != 3'd0;
      rsp_word.kind       = slots_ff[0].kind;
      rsp_word.data_byte  = slots_ff[0].data_byte;
      rsp_word.time_value = (slots_ff[0].kind == KIND_TIMESTAMP) ? time_ff : 64'd0;
      rsp_word.error_code = (slots_ff[0].kind == KIND_ERROR) ? err_ff : ERR_NONE;
      rsp_word.end_of_run = out_count_ff == 3'd1;
   end

`ifndef NO_ASSERTIONS
   // timestamps and errors only ever close a burst
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_word.kind == KIND_TIMESTAMP) || (rsp_word.kind == KIND_ERROR)))
      |-> rsp_word.end_of_run)
   else $error("timestamp or error word not last of its burst");

   // a decoded byte never yields more words than the queue holds
   assert property (@(posedge clock) disable iff (reset)
      advance |-> (new_burst.count <= 3'(MAX_RESULTS)))
   else $error("burst larger than result queue");

   // pending words are never overwritten by a new burst
   assert property (@(posedge clock) disable iff (reset)
      (out_count_ff > 3'd1) |-> !advance)
   else $error("burst loaded over pending words");

   // a byte waiting behind a busy queue goes through once the queue drains
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && (out_count_ff == 3'd0)) |=> !$stable(out_count_ff) || !in_valid_ff
      || (out_count_ff == 3'd0))
   else $error("input byte not decoded while queue empty");
`endif

endmodule

`default_nettype wire

// ===== test/vcd_byte_stream_lexer_unit_tb.sv =====
// vcd_byte_stream_lexer_unit_tb: self-checking bench for the dump text lexer, with short
// directed runs, then random token streams under random idle and stall on both channels.
// Depends on vcdlex_pkg and the vcd_byte_stream_lexer_unit top level.
`timescale 1ns / 1ps

module vcd_byte_stream_lexer_unit_tb;
   import vcdlex_pkg::*;

   localparam logic [63:0] TIME_TOP = {64{1'b1}} >> (64 - TIME_BITS_DEFAULT);
   localparam int unsigned RANDOM_BYTES = 150;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // byte stream waiting to be offered, and the words the lexer still owes us
   req_word_type text_pending[$];
   rsp_word_type token_words_due[$];
   rsp_word_type step_words[$];
   logic [7:0]   run_text[$];

   // shadow lexer state
   mode_type     lx_mode = MODE_IDLE;
   logic [63:0]  lx_time = '0;
   logic         lx_digit = 1'b0;
   logic         lx_done = 1'b0;
   logic [7:0]   lx_held [4];
   int unsigned  lx_held_n = 0;
   logic         lx_err = 1'b0;

   int unsigned  mism_count = 0;
   int unsigned  directed_n = 0;
   int unsigned  req_left = 0;
   int unsigned  rsp_left = 0;
   logic         req_calm = 1'b0;
   logic         rsp_calm = 1'b1;

   vcd_byte_stream_lexer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- shadow lexer

   function automatic logic blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

   function automatic void put_word(input kind_type k, input logic [7:0] b,
                                    input logic [63:0] t, input err_code_type e);
      rsp_word_type w;
      if (step_words.size() >= MAX_RESULTS) return;
      w.kind       = k;
      w.data_byte  = b;
      w.time_value = t;
      w.error_code = e;
      w.end_of_run = 1'b0;
      step_words = {step_words, w};
   endfunction

   function automatic void fail_with(input err_code_type e);
      put_word(KIND_ERROR, 8'h00, 64'd0, e);
      lx_err = 1'b1;
   endfunction

   function automatic void hold_byte(input logic [7:0] c);
      if (lx_held_n < 4) begin
         lx_held[lx_held_n] = c;
         lx_held_n++;
      end
   endfunction

   // held dollar word turned out not to be the closing word
   function automatic void release_held(input kind_type k, input int unsigned first);
      int unsigned i;
      for (i = first; i < lx_held_n; i++)
         put_word(k, lx_held[i], 64'd0, ERR_NONE);
      lx_held_n = 0;
   endfunction

   function automatic logic extends_end(input logic [7:0] c);
      logic [7:0] want;
      case (lx_held_n)
         0:       want = CHAR_DOLLAR;
         1:       want = CHAR_E;
         2:       want = CHAR_N;
         default: want = CHAR_D;
      endcase
      return (lx_held_n < 4) && (c == want);
   endfunction

   function automatic void open_token(input logic [7:0] c);
      if (blank(c)) return;
      if (c == CHAR_DOLLAR) begin
         lx_held_n = 0;
         hold_byte(c);
         lx_mode = MODE_KW_HOLD;
      end else if (c == CHAR_HASH) begin
         lx_time  = '0;
         lx_digit = 1'b0;
         lx_done  = 1'b0;
         lx_mode  = MODE_TIME;
      end else if (c == CHAR_0 || c == CHAR_1 || c == CHAR_X || c == CHAR_Z) begin
         put_word(KIND_VALUE, c, 64'd0, ERR_NONE);
         lx_mode = MODE_SC_VAL;
      end else if (c == CHAR_B || c == CHAR_R) begin
         put_word(KIND_VALUE, c, 64'd0, ERR_NONE);
         lx_mode = MODE_VEC_VAL;
      end else begin
         fail_with(ERR_UNEXPECTED);
      end
   endfunction

   function automatic void close_time();
      if (lx_digit) begin
         put_word(KIND_TIMESTAMP, 8'h00, lx_time, ERR_NONE);
         lx_mode = MODE_IDLE;
      end else begin
         fail_with(ERR_EMPTY_TIME);
      end
   endfunction

   function automatic void advance(input logic [7:0] c);
      logic        ws;
      logic [63:0] d;
      ws = blank(c);
      case (lx_mode)
         MODE_KW_HOLD: begin
            if (ws) begin
               if (lx_held_n == 4) begin
                  // "$end" right where a keyword belongs
                  lx_held_n = 0;
                  put_word(KIND_SECTION_END, 8'h00, 64'd0, ERR_NONE);
                  lx_mode = MODE_IDLE;
               end else begin
                  release_held(KIND_KEYWORD, 1);
                  lx_mode = MODE_BODY_WS;
               end
            end else if (extends_end(c)) begin
               hold_byte(c);
            end else begin
               release_held(KIND_KEYWORD, 1);
               put_word(KIND_KEYWORD, c, 64'd0, ERR_NONE);
               lx_mode = MODE_KW;
            end
         end
         MODE_KW: begin
            if (ws) lx_mode = MODE_BODY_WS;
            else put_word(KIND_KEYWORD, c, 64'd0, ERR_NONE);
         end
         MODE_BODY_WS: begin
            if (c == CHAR_DOLLAR) begin
               lx_held_n = 0;
               hold_byte(c);
               lx_mode = MODE_BODY_HOLD;
            end else begin
               put_word(KIND_BODY, c, 64'd0, ERR_NONE);
               if (!ws) lx_mode = MODE_BODY_WORD;
            end
         end
         MODE_BODY_WORD: begin
            put_word(KIND_BODY, c, 64'd0, ERR_NONE);
            if (ws) lx_mode = MODE_BODY_WS;
         end
         MODE_BODY_HOLD: begin
            if (ws) begin
               if (lx_held_n == 4) begin
                  lx_held_n = 0;
                  put_word(KIND_SECTION_END, 8'h00, 64'd0, ERR_NONE);
                  lx_mode = MODE_IDLE;
               end else begin
                  release_held(KIND_BODY, 0);
                  put_word(KIND_BODY, c, 64'd0, ERR_NONE);
                  lx_mode = MODE_BODY_WS;
               end
            end else if (extends_end(c)) begin
               hold_byte(c);
            end else begin
               release_held(KIND_BODY, 0);
               put_word(KIND_BODY, c, 64'd0, ERR_NONE);
               lx_mode = MODE_BODY_WORD;
            end
         end
         MODE_TIME: begin
            if (ws) begin
               close_time();
            end else if (lx_done) begin
               // junk after the digits is skipped
            end else if (c >= CHAR_0 && c <= CHAR_9) begin
               d = {56'd0, c - CHAR_0};
               if (lx_time > (TIME_TOP - d) / 64'd10) begin
                  fail_with(ERR_OVERFLOW);
               end else begin
                  lx_time  = lx_time * 64'd10 + d;
                  lx_digit = 1'b1;
               end
            end else if (lx_digit) begin
               lx_done = 1'b1;
            end else begin
               fail_with(ERR_EMPTY_TIME);
            end
         end
         MODE_SC_VAL: begin
            if (ws) begin
               fail_with(ERR_UNEXPECTED);
            end else begin
               put_word(KIND_ID, c, 64'd0, ERR_NONE);
               lx_mode = MODE_SC_ID;
            end
         end
         MODE_SC_ID, MODE_VEC_ID: begin
            if (ws) begin
               put_word(KIND_CHANGE_END, 8'h00, 64'd0, ERR_NONE);
               lx_mode = MODE_IDLE;
            end else begin
               put_word(KIND_ID, c, 64'd0, ERR_NONE);
            end
         end
         MODE_VEC_VAL: begin
            if (ws) lx_mode = MODE_VEC_GAP;
            else put_word(KIND_VALUE, c, 64'd0, ERR_NONE);
         end
         MODE_VEC_GAP: begin
            if (!ws) begin
               put_word(KIND_ID, c, 64'd0, ERR_NONE);
               lx_mode = MODE_VEC_ID;
            end
         end
         default: begin
            lx_mode = MODE_IDLE;
            open_token(c);
         end
      endcase
   endfunction

   // last byte closes whatever word is open
   function automatic void wrap_up();
      case (lx_mode)
         MODE_KW_HOLD, MODE_BODY_HOLD: begin
            if (lx_held_n == 4) begin
               lx_held_n = 0;
               put_word(KIND_SECTION_END, 8'h00, 64'd0, ERR_NONE);
            end else begin
               if (lx_mode == MODE_KW_HOLD) release_held(KIND_KEYWORD, 1);
               else release_held(KIND_BODY, 0);
               fail_with(ERR_MISSING_END);
            end
         end
         MODE_KW, MODE_BODY_WS, MODE_BODY_WORD: fail_with(ERR_MISSING_END);
         MODE_TIME: close_time();
         MODE_SC_ID, MODE_VEC_ID: put_word(KIND_CHANGE_END, 8'h00, 64'd0, ERR_NONE);
         MODE_SC_VAL, MODE_VEC_VAL, MODE_VEC_GAP: fail_with(ERR_UNEXPECTED);
         default: begin
         end
      endcase
   endfunction

   function automatic void lexer_clear();
      lx_mode   = MODE_IDLE;
      lx_time   = '0;
      lx_digit  = 1'b0;
      lx_done   = 1'b0;
      lx_held_n = 0;
      lx_err    = 1'b0;
   endfunction

   // work out the burst of words one accepted byte must produce
   function automatic void tokenize_byte(input req_word_type w);
      int unsigned  i;
      rsp_word_type r;
      step_words.delete();
      if (!lx_err) begin
         advance(w.byte_in);
         if (!lx_err && w.last_byte) wrap_up();
      end
      if (w.last_byte) lexer_clear();
      for (i = 0; i < step_words.size(); i++) begin
         r = step_words[i];
         r.end_of_run = (i == step_words.size() - 1);
         token_words_due = {token_words_due, r};
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag(input string what, input logic [63:0] got,
                       input logic [63:0] want);
      $display("mismatch: %s got %0h want %0h", what, got, want);
      mism_count++;
   endtask

   task automatic check_token_word(input rsp_word_type got);
      rsp_word_type want;
      if (token_words_due.size() == 0) begin
         flag("word with none due, kind", 64'(got.kind), 64'd0);
         return;
      end
      want = token_words_due.pop_front();
      if (got.kind != want.kind) flag("kind", 64'(got.kind), 64'(want.kind));
      if (got.data_byte != want.data_byte)
         flag("data_byte", 64'(got.data_byte), 64'(want.data_byte));
      if (got.time_value != want.time_value)
         flag("time_value", got.time_value, want.time_value);
      if (got.error_code != want.error_code)
         flag("error_code", 64'(got.error_code), 64'(want.error_code));
      if (got.end_of_run != want.end_of_run)
         flag("end_of_run", 64'(got.end_of_run), 64'(want.end_of_run));
   endtask

   function automatic int unsigned pick_gap(input logic calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // ---------------------------------------------------------------- byte driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_left = 0;
      end else if (req_valid && req_stall) begin
         // held word stays put
      end else begin
         if (req_valid) begin
            tokenize_byte(req_word);
            if ($urandom_range(0, 24) == 0) req_calm = !req_calm;
            req_left = pick_gap(req_calm);
         end
         if (req_left == 0 && text_pending.size() != 0) begin
            req_word  <= text_pending.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            if (req_left != 0) req_left = req_left - 1;
         end
      end
   end

   // ---------------------------------------------------------------- token monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_left = 0;
      end else if (rsp_stall) begin
         if (rsp_left <= 1) rsp_stall <= 1'b0;
         else rsp_left = rsp_left - 1;
      end else if (rsp_valid) begin
         check_token_word(rsp_word);
         if ($urandom_range(0, 24) == 0) rsp_calm = !rsp_calm;
         rsp_left = pick_gap(rsp_calm);
         if (rsp_left != 0) rsp_stall <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- dump text builders

   function automatic void append_byte(input logic [7:0] c);
      run_text = {run_text, c};
   endfunction

   function automatic void add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) append_byte(s[i]);
   endfunction

   // mark the final byte of the run and queue it all
   function automatic void close_run();
      int unsigned  i;
      req_word_type w;
      for (i = 0; i < run_text.size(); i++) begin
         w.byte_in   = run_text[i];
         w.last_byte = (i == run_text.size() - 1);
         text_pending = {text_pending, w};
      end
      run_text.delete();
   endfunction

   function automatic void add_blank();
      int n;
      int i;
      n = $urandom_range(1, 2);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0:       append_byte(CHAR_SPACE);
            1:       append_byte(CHAR_TAB);
            2:       append_byte(CHAR_LF);
            default: append_byte(CHAR_CR);
         endcase
      end
   endfunction

   function automatic void add_id();
      int n;
      int i;
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) append_byte(8'($urandom_range(33, 126)));
   endfunction

   function automatic void add_digits(input int n);
      int i;
      for (i = 0; i < n; i++) append_byte(8'(CHAR_0 + $urandom_range(0, 9)));
   endfunction

   function automatic logic [7:0] scalar_char();
      case ($urandom_range(0, 3))
         0:       return CHAR_0;
         1:       return CHAR_1;
         2:       return CHAR_X;
         default: return CHAR_Z;
      endcase
   endfunction

   function automatic void add_section();
      int k;
      int n;
      int i;
      int j;
      k = $urandom_range(0, 9);
      if (k == 0) begin
         add_text("$end");
         return;
      end
      if (k == 1) add_text("$e");
      else if (k == 2) add_text("$endx");
      else begin
         append_byte(CHAR_DOLLAR);
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) append_byte(8'("a" + $urandom_range(0, 25)));
      end
      add_blank();
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 11))
            0: add_text("$");
            1: add_text("$e");
            2: add_text("$en");
            3: add_text("$enx");
            4: add_text("$endd");
            5: add_text("$var");
            6: append_byte(8'($urandom_range(128, 255)));
            default: begin
               k = $urandom_range(1, 5);
               for (j = 0; j < k; j++) append_byte(8'($urandom_range(33, 126)));
            end
         endcase
         add_blank();
      end
      // now and then the closing word is missing
      if ($urandom_range(0, 7) != 0) add_text("$end");
   endfunction

   function automatic void add_stamp();
      case ($urandom_range(0, 19))
         0: add_text("#18446744073709551615");
         1: add_text("#18446744073709551616");
         2: begin
            append_byte(CHAR_HASH);
            append_byte(8'(CHAR_1 + $urandom_range(0, 8)));
            add_digits(19);
         end
         3: append_byte(CHAR_HASH);
         4: begin
            append_byte(CHAR_HASH);
            add_digits($urandom_range(1, 4));
            add_text("ab");
            add_digits(1);
         end
         5: add_text("#q");
         6: add_text("#0");
         default: begin
            append_byte(CHAR_HASH);
            add_digits($urandom_range(1, 6));
         end
      endcase
   endfunction

   function automatic void add_scalar();
      append_byte(scalar_char());
      if ($urandom_range(0, 9) != 0) add_id();
   endfunction

   function automatic void add_vector();
      int n;
      int i;
      n = $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) begin
         append_byte(CHAR_B);
         for (i = 0; i < n; i++) append_byte(scalar_char());
      end else begin
         append_byte(CHAR_R);
         add_digits(n);
         add_text(".");
         add_digits(1);
      end
      if ($urandom_range(0, 9) != 0) begin
         add_blank();
         add_id();
      end
   endfunction

   function automatic void add_noise();
      int n;
      int i;
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) append_byte(8'($urandom_range(0, 255)));
   endfunction

   // one random stretch of dump text, closed by a last byte
   function automatic void add_random_run();
      int n;
      int i;
      int p;
      int keep;
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) begin
         if (i != 0) add_blank();
         p = $urandom_range(0, 99);
         if (p < 20) add_section();
         else if (p < 40) add_stamp();
         else if (p < 65) add_scalar();
         else if (p < 88) add_vector();
         else add_noise();
      end
      if ($urandom_range(0, 1) != 0) add_blank();
      // sometimes the text stops in the middle of a word
      if ($urandom_range(0, 9) == 0 && run_text.size() > 1) begin
         keep = $urandom_range(1, run_text.size() - 1);
         while (run_text.size() > keep) run_text.delete(run_text.size() - 1);
      end
      close_run();
   endfunction

   // ---------------------------------------------------------------- sequence

   initial begin
      // closing word in keyword position, ended by the last byte
      add_text("$end");
      close_run();
      // scalar change closed by the last byte
      add_text("1!");
      close_run();
      // timestamp with no digit
      add_text("#x");
      close_run();
      // unknown start, top bit set
      append_byte(8'hff);
      close_run();
      // vector value that never gets its identifier
      add_text("b1 ");
      close_run();
      // held dollar word flushed as body, then section left open
      add_text("$a $e");
      close_run();
      // scalar with no identifier
      add_text("0\t");
      close_run();
      // junk after timestamp digits
      add_text("#5z");
      close_run();
      directed_n = text_pending.size();

      while (text_pending.size() < directed_n + RANDOM_BYTES) add_random_run();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (text_pending.size() != 0 || req_valid) @(posedge clock);
      while (token_words_due.size() != 0) @(posedge clock);
      // give stray words a chance to show up
      repeat (20) @(posedge clock);
      if (token_words_due.size() != 0)
         flag("words never delivered", 64'(token_words_due.size()), 64'd0);

      if (mism_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/vcdlex_pkg.sv
hw/rtl/vcdlex_core.sv
hw/rtl/vcd_byte_stream_lexer_unit.sv
test/vcd_byte_stream_lexer_unit_tb.sv
